@@ hdl/pcl_pkg.sv @@
`timescale 1ns / 1ps

package pcl_pkg;

	// Defaults for the top-level parameters
	localparam int STATES_DEF    = 4;
	localparam int CLASSES_DEF   = 4;
	localparam int FRAC_BITS_DEF = 31;

	// Fixed port geometry
	localparam int LANES  = 4;
	localparam int LANE_W = 32;

	typedef enum logic {
		FUNC_LOAD    = 1'b0,
		FUNC_COMPUTE = 1'b1
	} func_t;

endpackage

@@ hdl/pcl_ram.sv @@
`timescale 1ns / 1ps

module pcl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// hold read data while the consumer stalls
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hdl/pruning_conditional_likelihood.sv @@
`timescale 1ns / 1ps

// Throughput: one word per cycle on both channels while out_ready is high; load and
//   compute words mix freely. A compute word is registered through the table read, the
//   lane products, the row sums, and the parent product and saturation before output.
// Load words write the transition table at their acceptance edge and produce no output word.
// Reset (arst_n low, asynchronous) empties the pipeline; the table keeps no reset value.
module pruning_conditional_likelihood #(
	parameter int STATES    = pcl_pkg::STATES_DEF,
	parameter int CLASSES   = pcl_pkg::CLASSES_DEF,
	parameter int FRAC_BITS = pcl_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic        son,
	input  logic [1:0]  rate_class,
	input  logic [1:0]  row,
	input  logic [31:0] lane_a0,
	input  logic [31:0] lane_a1,
	input  logic [31:0] lane_a2,
	input  logic [31:0] lane_a3,
	input  logic [31:0] parent_l0,
	input  logic [31:0] parent_l1,
	input  logic [31:0] parent_l2,
	input  logic [31:0] parent_l3,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] new_l0,
	output logic [31:0] new_l1,
	output logic [31:0] new_l2,
	output logic [31:0] new_l3
);

	// Values are clamped to 1.0 on entry, so FRAC_BITS+1 bits hold every operand.
	localparam int VW    = FRAC_BITS + 1;
	localparam int DEPTH = 2 * CLASSES;
	localparam int AW    = $clog2(DEPTH);
	localparam int LW    = pcl_pkg::LANE_W;
	localparam int RW    = STATES * LW;
	localparam logic [VW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	function automatic logic [VW-1:0] clamp_one(input logic [LW-1:0] v);
		if (v > LW'(ONE)) begin
			return ONE;
		end
		return VW'(v);
	endfunction

	// ------------------------------------------------------------------
	// Port gathering
	// ------------------------------------------------------------------
	logic [LW-1:0] lane_in   [pcl_pkg::LANES];
	logic [LW-1:0] parent_in [pcl_pkg::LANES];
	logic [LW-1:0] new_out   [pcl_pkg::LANES];

	assign lane_in[0]   = lane_a0;
	assign lane_in[1]   = lane_a1;
	assign lane_in[2]   = lane_a2;
	assign lane_in[3]   = lane_a3;
	assign parent_in[0] = parent_l0;
	assign parent_in[1] = parent_l1;
	assign parent_in[2] = parent_l2;
	assign parent_in[3] = parent_l3;
	assign new_l0       = new_out[0];
	assign new_l1       = new_out[1];
	assign new_l2       = new_out[2];
	assign new_l3       = new_out[3];

	// ------------------------------------------------------------------
	// Stage advance: each stage moves when it is empty or the next one moves,
	// so a bubble anywhere in the pipe is absorbed while the output stalls.
	// ------------------------------------------------------------------
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic adv1, adv2, adv3, adv4;

	assign adv4     = !valid_s4 || out_ready;
	assign adv3     = !valid_s3 || adv4;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign in_ready = adv1;

	logic accept;
	logic is_compute;
	logic cls_ok;
	logic row_ok;
	logic load_we;
	logic [AW-1:0] tbl_addr;

	assign accept     = in_valid && in_ready;
	assign is_compute = (func == pcl_pkg::FUNC_COMPUTE);
	assign cls_ok     = int'(rate_class) < CLASSES;
	assign row_ok     = int'(row) < STATES;
	// Loads to rows or classes outside the table are dropped.
	assign load_we    = accept && !is_compute && row_ok && cls_ok;
	// One table word per (son, class); an out-of-range class reads word 0 and is zeroed later.
	assign tbl_addr   = cls_ok ? AW'(int'(son) * CLASSES + int'(rate_class)) : '0;

	// ------------------------------------------------------------------
	// Transition table: one RAM per matrix row, each word holds the whole row.
	// All rows of one (son, class) come out together, registered into stage 1.
	// ------------------------------------------------------------------
	logic [RW-1:0] row_wdata;
	logic [RW-1:0] prow_s1 [STATES];

	always_comb begin
		for (int y = 0; y < STATES; y++) begin
			row_wdata[y*LW +: LW] = lane_in[y];
		end
	end

	for (genvar x = 0; x < STATES; x++) begin : g_row
		pcl_ram #(
			.WIDTH(RW),
			.DEPTH(DEPTH)
		) u_ram (
			.clk  (clk),
			.we   (load_we && (int'(row) == x)),
			.waddr(tbl_addr),
			.wdata(row_wdata),
			.re   (adv1),
			.raddr(tbl_addr),
			.rdata(prow_s1[x])
		);
	end

	// ------------------------------------------------------------------
	// Stage 1: clamped son and parent vectors alongside the table read
	// ------------------------------------------------------------------
	logic [VW-1:0] lane_s1   [STATES];
	logic [VW-1:0] parent_s1 [STATES];
	logic          cls_ok_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv1) begin
			valid_s1 <= accept && is_compute;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			for (int y = 0; y < STATES; y++) begin
				lane_s1[y]   <= clamp_one(lane_in[y]);
				parent_s1[y] <= clamp_one(parent_in[y]);
			end
			cls_ok_s1 <= cls_ok;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: P[x][y] * son[y], truncated to FRAC_BITS fraction bits
	// ------------------------------------------------------------------
	logic [2*VW-1:0] prod_full [STATES][STATES];
	logic [VW-1:0]   prod_s2   [STATES][STATES];
	logic [VW-1:0]   parent_s2 [STATES];
	logic            cls_ok_s2;

	always_comb begin
		for (int x = 0; x < STATES; x++) begin
			for (int y = 0; y < STATES; y++) begin
				prod_full[x][y] = (2*VW)'(clamp_one(prow_s1[x][y*LW +: LW]))
					* (2*VW)'(lane_s1[y]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			for (int x = 0; x < STATES; x++) begin
				for (int y = 0; y < STATES; y++) begin
					// both factors are at most 1.0, so the product fits VW bits
					prod_s2[x][y] <= prod_full[x][y][FRAC_BITS +: VW];
				end
			end
			parent_s2 <= parent_s1;
			cls_ok_s2 <= cls_ok_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: row sums, saturated at 1.0
	// ------------------------------------------------------------------
	logic [VW+1:0] row_sum   [STATES];
	logic [VW-1:0] sum_s3    [STATES];
	logic [VW-1:0] parent_s3 [STATES];
	logic          cls_ok_s3;

	always_comb begin
		for (int x = 0; x < STATES; x++) begin
			row_sum[x] = '0;
			for (int y = 0; y < STATES; y++) begin
				row_sum[x] = row_sum[x] + (VW+2)'(prod_s2[x][y]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			for (int x = 0; x < STATES; x++) begin
				sum_s3[x] <= (row_sum[x] > (VW+2)'(ONE)) ? ONE : VW'(row_sum[x]);
			end
			parent_s3 <= parent_s2;
			cls_ok_s3 <= cls_ok_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4 (output register): parent times row sum (zero for a class outside the table), truncated, saturated
	// ------------------------------------------------------------------
	logic [2*VW-1:0] fin_full [STATES];
	logic [VW-1:0]   fin_s4   [STATES];

	always_comb begin
		for (int x = 0; x < STATES; x++) begin
			fin_full[x] = (2*VW)'(parent_s3[x]) * (2*VW)'(sum_s3[x]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv4) begin
			for (int x = 0; x < STATES; x++) begin
				if (!cls_ok_s3) begin
					// class outside the table behaves as an all-zero matrix
					fin_s4[x] <= '0;
				end else if (fin_full[x][FRAC_BITS +: VW+1] > (VW+1)'(ONE)) begin
					fin_s4[x] <= ONE;
				end else begin
					fin_s4[x] <= fin_full[x][FRAC_BITS +: VW];
				end
			end
		end
	end

	assign out_valid = valid_s4;

	// States at or above STATES read as zero.
	always_comb begin
		for (int x = 0; x < pcl_pkg::LANES; x++) begin
			new_out[x] = '0;
		end
		for (int x = 0; x < STATES; x++) begin
			new_out[x] = LW'(fin_s4[x]);
		end
	end

endmodule

@@ hdl/pcl_checker.sv @@
`timescale 1ns / 1ps

module pcl_checker #(
	parameter int FRAC_BITS = pcl_pkg::FRAC_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] new_l0,
	input logic [31:0] new_l1,
	input logic [31:0] new_l2,
	input logic [31:0] new_l3
);

	localparam logic [31:0] ONE = 32'(64'(1) << FRAC_BITS);

	// a drained or draining output never blocks the input
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("input stalled while output side is free");

	// results never exceed 1.0
	a_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (new_l0 <= ONE && new_l1 <= ONE && new_l2 <= ONE && new_l3 <= ONE))
		else $error("result above 1.0");

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("output word dropped while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
			($stable(new_l0) && $stable(new_l1) && $stable(new_l2) && $stable(new_l3)))
		else $error("output word changed while stalled");

endmodule

bind pruning_conditional_likelihood pcl_checker #(
	.FRAC_BITS(FRAC_BITS)
) u_pcl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.new_l0   (new_l0),
	.new_l1   (new_l1),
	.new_l2   (new_l2),
	.new_l3   (new_l3)
);
